[design/scpp_pkg.sv]
// Shared types and constants for the sync/checksum packet parser.
// Used by every module of the parser; depends on nothing.
package scpp_pkg;

  localparam int unsigned PacketLengthDef = 19;
  localparam int unsigned LimitW          = 16;
  localparam int unsigned CntW            = 32;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [7:0]        SYNC_BYTE       = 8'hAA;
  localparam logic [LimitW-1:0] IDLE_LIMIT_RST   = 16'd1000;
  localparam logic [LimitW-1:0] HEADER_LIMIT_RST = 16'd20;
  localparam logic [LimitW-1:0] BODY_LIMIT_RST   = 16'd30;

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_SYNC2 = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE = 3'd0,
    ST_OK   = 3'd1,
    ST_CSUM = 3'd2,
    ST_SYNC = 3'd3,
    ST_IDLE = 3'd4,
    ST_DROP = 3'd5
  } status_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IDLE_LIMIT   = 2'd0,
    CFG_HEADER_LIMIT = 2'd1,
    CFG_BODY_LIMIT   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    status_t         status;
    logic [CntW-1:0] good_packets;
    logic [CntW-1:0] bad_checksums;
    logic [CntW-1:0] sync_misses;
    logic [CntW-1:0] idle_timeouts;
    logic [7:0]      last_index;
  } out_item_t;

endpackage

[design/scpp_in_reg.sv]
// Input register of the packet parser: holds one accepted item until the
// engine consumes it. Depends on scpp_pkg.
module scpp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  scpp_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output scpp_pkg::in_item_t item
);
  import scpp_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

[design/scpp_engine.sv]
// Parser engine: limit registers, phase machine, counters and the result
// computed for the item in the input register. Depends on scpp_pkg.
module scpp_engine #(
  parameter int unsigned PACKET_LENGTH = scpp_pkg::PacketLengthDef
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  scpp_pkg::cfg_idx_t              cfg_index,
  input  logic [scpp_pkg::LimitW-1:0]     cfg_data,
  input  logic                            advance,
  input  scpp_pkg::in_item_t              item,
  output scpp_pkg::out_item_t             result
);
  import scpp_pkg::*;

  localparam int unsigned PosW = (PACKET_LENGTH - 2 > 1) ? $clog2(PACKET_LENGTH - 2) : 1;
  localparam logic [PosW-1:0] LastPos = PosW'(PACKET_LENGTH - 3);

  logic [LimitW-1:0] idle_limit_r, header_limit_r, body_limit_r;

  phase_t            phase_r, phase_nxt;
  logic [PosW-1:0]   pos_r, pos_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        pend_r, pend_nxt;
  logic [LimitW-1:0] wait_r, wait_nxt;
  logic [CntW-1:0]   good_r, good_nxt;
  logic [CntW-1:0]   csum_r, csum_nxt;
  logic [CntW-1:0]   miss_r, miss_nxt;
  logic [CntW-1:0]   tmo_r, tmo_nxt;
  logic [7:0]        saved_r, saved_nxt;
  status_t           status;

  logic [LimitW-1:0] wait_inc;
  logic [LimitW-1:0] limit;
  logic              expired;
  logic              is_sync;

  assign wait_inc = wait_r + 1'b1;
  assign is_sync  = (item.data_byte == SYNC_BYTE);

  always_comb begin
    unique case (phase_r)
      PH_SYNC2: limit = header_limit_r;
      PH_BODY:  limit = body_limit_r;
      default:  limit = idle_limit_r;
    endcase
  end

  assign expired = (wait_inc >= limit);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_SYNC2: begin
        if (item.mode) begin
          if (expired) phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = is_sync ? PH_BODY : PH_HUNT;
        end
      end
      PH_BODY: begin
        if (item.mode) begin
          if (expired) phase_nxt = PH_HUNT;
        end else if (pos_r == LastPos) begin
          phase_nxt = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = (!item.mode && is_sync) ? PH_SYNC2 : PH_HUNT;
      end
    endcase
  end

  // datapath and status
  always_comb begin
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    pend_nxt  = pend_r;
    wait_nxt  = wait_r;
    good_nxt  = good_r;
    csum_nxt  = csum_r;
    miss_nxt  = miss_r;
    tmo_nxt   = tmo_r;
    saved_nxt = saved_r;
    status    = ST_NONE;
    unique case (phase_r)
      PH_SYNC2: begin
        if (item.mode) begin
          wait_nxt = expired ? '0 : wait_inc;
          if (expired) status = ST_DROP;
        end else begin
          wait_nxt = '0;
          if (is_sync) begin
            pos_nxt = '0;
            sum_nxt = '0;
          end else begin
            status = ST_DROP;
          end
        end
      end
      PH_BODY: begin
        if (item.mode) begin
          wait_nxt = expired ? '0 : wait_inc;
          if (expired) status = ST_DROP;
        end else if (pos_r == LastPos) begin
          wait_nxt = '0;
          if (sum_r == item.data_byte) begin
            good_nxt  = good_r + 1'b1;
            saved_nxt = pend_r;
            status    = ST_OK;
          end else begin
            csum_nxt = csum_r + 1'b1;
            status   = ST_CSUM;
          end
        end else begin
          if (pos_r == '0) pend_nxt = item.data_byte;
          sum_nxt = sum_r + item.data_byte;
          pos_nxt = pos_r + 1'b1;
        end
      end
      default: begin
        if (item.mode) begin
          wait_nxt = expired ? '0 : wait_inc;
          if (expired) begin
            tmo_nxt = tmo_r + 1'b1;
            status  = ST_IDLE;
          end
        end else begin
          wait_nxt = '0;
          if (!is_sync) begin
            miss_nxt = miss_r + 1'b1;
            status   = ST_SYNC;
          end
        end
      end
    endcase
  end

  assign result.status        = status;
  assign result.good_packets  = good_nxt;
  assign result.bad_checksums = csum_nxt;
  assign result.sync_misses   = miss_nxt;
  assign result.idle_timeouts = tmo_nxt;
  assign result.last_index    = saved_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_limit_r   <= IDLE_LIMIT_RST;
      header_limit_r <= HEADER_LIMIT_RST;
      body_limit_r   <= BODY_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IDLE_LIMIT:   idle_limit_r   <= cfg_data;
        CFG_HEADER_LIMIT: header_limit_r <= cfg_data;
        CFG_BODY_LIMIT:   body_limit_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      pos_r   <= '0;
      sum_r   <= '0;
      pend_r  <= '0;
      wait_r  <= '0;
      good_r  <= '0;
      csum_r  <= '0;
      miss_r  <= '0;
      tmo_r   <= '0;
      saved_r <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      pend_r  <= pend_nxt;
      wait_r  <= wait_nxt;
      good_r  <= good_nxt;
      csum_r  <= csum_nxt;
      miss_r  <= miss_nxt;
      tmo_r   <= tmo_nxt;
      saved_r <= saved_nxt;
    end
  end

endmodule

[design/scpp_out_reg.sv]
// Result register of the packet parser: holds one result until taken and
// decides when the engine may advance. Depends on scpp_pkg.
module scpp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  scpp_pkg::out_item_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output scpp_pkg::out_item_t out_item
);
  import scpp_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  assign advance   = item_valid && (!valid_r || out_ready);
  assign valid_nxt = advance || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= result;
    end
  end

endmodule

[design/sync_checksum_packet_parser_core.sv]
// Top level of the sync/checksum packet parser.
// Depends on scpp_pkg, scpp_in_reg, scpp_engine and scpp_out_reg.
//
// Input items carry either a received byte (mode 0) or a one-millisecond
// tick (mode 1). Every input item produces exactly one result item with a
// status code and the current good, checksum-fail, sync-miss and timeout
// counters plus the index byte of the last good packet.
// Configuration writes (idle, header and body tick limits) use a separate
// channel that is always ready; they take effect on the next item.
// An accepted item sits in the input register; the engine's next-state logic
// then loads its result into the result register when that register is empty
// or being taken. Throughput is one item per cycle while out_ready stays high;
// the phase, sum and counter registers update once per accepted item.
// Reset clears phase to hunting, all counters and the valid flags of both
// stage registers and loads the default limits (1000, 20, 30 ticks).
// When the receiver holds out_ready low, the result register holds its item,
// the input register fills with one more item, and in_ready then drops until
// the result is taken.
module sync_checksum_packet_parser_core #(
  parameter int unsigned PACKET_LENGTH = scpp_pkg::PacketLengthDef
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  scpp_pkg::in_item_t          in_item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output scpp_pkg::out_item_t         out_item,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  scpp_pkg::cfg_idx_t          cfg_index,
  input  logic [scpp_pkg::LimitW-1:0] cfg_data
);
  import scpp_pkg::*;

  logic      advance;
  logic      item_valid;
  in_item_t  item;
  out_item_t result;

  assign cfg_ready = 1'b1;

  scpp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  scpp_engine #(
    .PACKET_LENGTH (PACKET_LENGTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  scpp_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

[test/tb.sv]
// Self-checking bench for sync_checksum_packet_parser_core: sync hunting,
// checksum, drop and idle-timeout paths under random gaps and stalls.
// Depends on scpp_pkg and the parser RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import scpp_pkg::*;

  localparam int unsigned BODY_SUMMED = PacketLengthDef - 3;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned LONG_HOLD = 300;
  localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(2'd3);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_IDLE_LIMIT;
  logic [LimitW-1:0] cfg_data = '0;

  in_item_t rx_stream[$];
  out_item_t expected_reports[$];
  int send_gap = 0;
  int hold_left = 0;
  bit quiet = 1'b0;
  bit long_hold_req = 1'b0;
  int error_count = 0;
  int cycle_count = 0;

  // parser state mirror
  phase_t parse_phase;
  logic [4:0] body_pos;
  logic [7:0] body_sum;
  logic [7:0] idx_pending;
  logic [7:0] idx_saved;
  logic [15:0] wait_cnt;
  logic [31:0] n_good;
  logic [31:0] n_csum;
  logic [31:0] n_miss;
  logic [31:0] n_timeouts;
  logic [15:0] idle_lim;
  logic [15:0] header_lim;
  logic [15:0] body_lim;

  sync_checksum_packet_parser_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void switch_phase(phase_t nxt);
    parse_phase = nxt;
    wait_cnt = '0;
    if (nxt == PH_BODY) begin
      body_pos = '0;
      body_sum = '0;
    end
  endfunction

  function automatic bit tick_hits(logic [15:0] lim);
    wait_cnt = wait_cnt + 16'd1;
    return wait_cnt >= lim;
  endfunction

  function automatic out_item_t parse_item(in_item_t it);
    out_item_t r;
    status_t st;
    st = ST_NONE;
    if (parse_phase != PH_SYNC2 && parse_phase != PH_BODY) parse_phase = PH_HUNT;
    if (it.mode) begin
      case (parse_phase)
        PH_SYNC2: begin
          if (tick_hits(header_lim)) begin
            switch_phase(PH_HUNT);
            st = ST_DROP;
          end
        end
        PH_BODY: begin
          if (tick_hits(body_lim)) begin
            switch_phase(PH_HUNT);
            st = ST_DROP;
          end
        end
        default: begin
          if (tick_hits(idle_lim)) begin
            n_timeouts = n_timeouts + 32'd1;
            wait_cnt = '0;
            st = ST_IDLE;
          end
        end
      endcase
    end else begin
      case (parse_phase)
        PH_SYNC2: begin
          if (it.data_byte == SYNC_BYTE) begin
            switch_phase(PH_BODY);
          end else begin
            switch_phase(PH_HUNT);
            st = ST_DROP;
          end
        end
        PH_BODY: begin
          if (body_pos == BODY_SUMMED) begin
            if (body_sum == it.data_byte) begin
              n_good = n_good + 32'd1;
              idx_saved = idx_pending;
              st = ST_OK;
            end else begin
              n_csum = n_csum + 32'd1;
              st = ST_CSUM;
            end
            switch_phase(PH_HUNT);
          end else begin
            if (body_pos == 5'd0) idx_pending = it.data_byte;
            body_sum = body_sum + it.data_byte;
            body_pos = body_pos + 5'd1;
          end
        end
        default: begin
          if (it.data_byte == SYNC_BYTE) begin
            switch_phase(PH_SYNC2);
          end else begin
            n_miss = n_miss + 32'd1;
            switch_phase(PH_HUNT);
            st = ST_SYNC;
          end
        end
      endcase
    end
    r.status = st;
    r.good_packets = n_good;
    r.bad_checksums = n_csum;
    r.sync_misses = n_miss;
    r.idle_timeouts = n_timeouts;
    r.last_index = idx_saved;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  task automatic check_report(out_item_t want, out_item_t got);
    compare_field("status", 32'(want.status), 32'(got.status));
    compare_field("good_packets", want.good_packets, got.good_packets);
    compare_field("bad_checksums", want.bad_checksums, got.bad_checksums);
    compare_field("sync_misses", want.sync_misses, got.sync_misses);
    compare_field("idle_timeouts", want.idle_timeouts, got.idle_timeouts);
    compare_field("last_index", 32'(want.last_index), 32'(got.last_index));
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_reports.push_back(parse_item(in_item));
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_item <= rx_stream.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
        end else begin
          check_report(expected_reports.pop_front(), out_item);
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (quiet) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          hold_left = (r < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b);
    in_item_t it;
    it.mode = 1'b0;
    it.data_byte = b;
    rx_stream.push_back(it);
  endtask

  task automatic push_tick();
    in_item_t it;
    it.mode = 1'b1;
    it.data_byte = 8'($urandom_range(0, 255));
    rx_stream.push_back(it);
  endtask

  task automatic scatter_ticks(int pct);
    if ($urandom_range(0, 99) < pct) begin
      repeat ($urandom_range(1, 2)) push_tick();
    end
  endtask

  // fill < 0 gives random body bytes
  task automatic queue_packet(bit bad_sync2, bit bad_sum, int pct, int fill);
    logic [7:0] sum;
    logic [7:0] b;
    push_byte(SYNC_BYTE);
    scatter_ticks(pct);
    if (bad_sync2) begin
      b = 8'($urandom_range(0, 255));
      if (b == SYNC_BYTE) b = ~SYNC_BYTE;
      push_byte(b);
      return;
    end
    push_byte(SYNC_BYTE);
    sum = '0;
    for (int i = 0; i < BODY_SUMMED; i++) begin
      scatter_ticks(pct);
      b = (fill < 0) ? 8'($urandom_range(0, 255)) : fill[7:0];
      push_byte(b);
      sum = sum + b;
    end
    scatter_ticks(pct);
    push_byte(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
  endtask

  task automatic queue_random(int n);
    int r;
    int pct;
    while (rx_stream.size() < n) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: pct = 0;
        1: pct = 5;
        2: pct = 15;
        default: pct = 30;
      endcase
      if (r < 55) queue_packet(1'b0, 1'b0, pct, -1);
      else if (r < 65) queue_packet(1'b0, 1'b1, pct, -1);
      else if (r < 72) queue_packet(1'b1, 1'b0, pct, -1);
      else if (r < 86) repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      else repeat ($urandom_range(1, 30)) push_tick();
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IDLE_LIMIT:   idle_lim = val;
      CFG_HEADER_LIMIT: header_lim = val;
      CFG_BODY_LIMIT:   body_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(logic [15:0] idle, logic [15:0] hdr, logic [15:0] body);
    write_reg(CFG_IDLE_LIMIT, idle);
    write_reg(CFG_HEADER_LIMIT, hdr);
    write_reg(CFG_BODY_LIMIT, body);
  endtask

  task automatic drain();
    while (rx_stream.size() != 0 || in_valid || expected_reports.size() != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    parse_phase = PH_HUNT;
    body_pos = '0;
    body_sum = '0;
    idx_pending = '0;
    idx_saved = '0;
    wait_cnt = '0;
    n_good = '0;
    n_csum = '0;
    n_miss = '0;
    n_timeouts = '0;
    idle_lim = IDLE_LIMIT_RST;
    header_lim = HEADER_LIMIT_RST;
    body_lim = BODY_LIMIT_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_byte(8'h00);
    push_byte(8'hFF);
    queue_packet(1'b0, 1'b0, 0, 8'hFF);
    drain();

    set_limits(16'd1, 16'd1, 16'd1);
    push_tick();
    push_byte(SYNC_BYTE);
    push_tick();
    push_byte(SYNC_BYTE);
    push_byte(SYNC_BYTE);
    push_tick();
    push_byte(SYNC_BYTE);
    push_byte(~SYNC_BYTE);
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        1: set_limits(16'd0, 16'd0, 16'd0);
        2: begin
          set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(1, 6)),
                     16'($urandom_range(2, 24)));
          write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
        end
        default: set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(1, 6)),
                            16'($urandom_range(2, 24)));
      endcase
      quiet = (p == 3);
      queue_random(ITEMS_PER_PHASE);
      if (p == 5) long_hold_req = 1'b1;
      drain();
    end
    quiet = 1'b0;

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
